@@ rtl/rig_pkg.sv @@
// Shared types and constants of the resample index generator.
// No dependencies; every other file of the block imports this package.
package rig_pkg;

	localparam int RIG_MAX_SAMPLES_DEF = 1024;

	localparam int RIG_FRAC_W     = 32;
	localparam int RIG_COUNT_W    = 11;
	localparam int RIG_RATIO_W    = 17;
	localparam int RIG_RATIO_FRAC = 16;
	localparam int RIG_IDX_W      = 10;
	localparam int RIG_CFG_IDX_W  = 2;
	localparam int RIG_CFG_DATA_W = 17;

	// register indexes of the configuration port
	localparam logic [RIG_CFG_IDX_W-1:0] RIG_REG_MODE  = 2'd0;
	localparam logic [RIG_CFG_IDX_W-1:0] RIG_REG_COUNT = 2'd1;
	localparam logic [RIG_CFG_IDX_W-1:0] RIG_REG_RATIO = 2'd2;

	localparam logic                    RIG_MODE_BOOT  = 1'b0;
	localparam logic                    RIG_MODE_JACK  = 1'b1;
	localparam logic [RIG_COUNT_W-1:0]  RIG_COUNT_RST  = 11'd1024;
	localparam logic [RIG_RATIO_W-1:0]  RIG_RATIO_RST  = 17'd32768;
	localparam logic [RIG_RATIO_W-1:0]  RIG_RATIO_ONE  = 17'd65536;

	typedef struct packed {
		logic ready;      // draw channel open
		logic accept;     // draw transfer this cycle
		logic sweep;      // write one identity entry
		logic mul;        // form the draw product
		logic rd;         // read table at pick and draw position
		logic wr1;        // write table at pick
		logic wr2;        // write table at draw position
		logic load_boot;  // load result from the product
		logic load_jack;  // load result from the table
	} rig_cmd_t;

	typedef struct packed {
		logic run_over;   // draw counter at or past the run total
		logic sweep_last; // current sweep entry is the last dirty one
		logic clean_zero; // no table entry dirtied since the last reload
		logic jack;       // jackknife mode
		logic out_free;   // result register can take a new result
	} rig_sts_t;

endpackage

@@ rtl/rig_draw_if.sv @@
// Draw channel: one random fraction and the restart flag per transfer.
// Depends on rig_pkg.
interface rig_draw_if;
	import rig_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [RIG_FRAC_W-1:0] random_fraction;
	logic                  new_run;

	modport source (output valid, random_fraction, new_run, input ready);
	modport sink   (input valid, random_fraction, new_run, output ready);
endinterface

@@ rtl/rig_result_if.sv @@
// Result channel: one resampling index per transfer.
// Depends on rig_pkg.
interface rig_result_if;
	import rig_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [RIG_IDX_W-1:0] sample_index;
	logic [RIG_IDX_W-1:0] draw_number;
	logic                 last_in_run;

	modport source (output valid, sample_index, draw_number, last_in_run, input ready);
	modport sink   (input valid, sample_index, draw_number, last_in_run, output ready);
endinterface

@@ rtl/resample_index_generator_core.sv @@
// Top level of the resample index generator: sequencer, datapath and channels.
// Depends on rig_pkg, rig_draw_if, rig_result_if, rig_ctrl and rig_datapath.
//
//   channel   dir   handshake      payload
//   draw      in    valid/ready    random_fraction[31:0], new_run
//   result    out   valid/ready    sample_index[9:0], draw_number[9:0], last_in_run
//   wr_*      in    wr_en only     wr_index[1:0], wr_data[16:0]
//
// A bootstrap draw multiplies and then loads its result; a jackknife draw swaps through
// the table: one read on both read ports, then two writes on the single write port.
// A draw with new_run first reloads, one entry a cycle, every table entry up to
// the highest pick since the last reload (at most MAX_SAMPLES). After reset the
// whole table of MAX_SAMPLES entries is loaded before draw goes ready.
// A full result register stalls a draw before its result is loaded.
module resample_index_generator_core #(
	parameter int MAX_SAMPLES = rig_pkg::RIG_MAX_SAMPLES_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               wr_en,
	input  logic [rig_pkg::RIG_CFG_IDX_W-1:0]  wr_index,
	input  logic [rig_pkg::RIG_CFG_DATA_W-1:0] wr_data,
	rig_draw_if.sink                           draw,
	rig_result_if.source                       result
);
	import rig_pkg::*;

	rig_cmd_t cmd;
	rig_sts_t sts;

	rig_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (draw.valid),
		.new_run  (draw.new_run),
		.sts      (sts),
		.cmd      (cmd)
	);

	rig_datapath #(
		.MAX_SAMPLES (MAX_SAMPLES)
	) u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.wr_en           (wr_en),
		.wr_index        (wr_index),
		.wr_data         (wr_data),
		.random_fraction (draw.random_fraction),
		.new_run         (draw.new_run),
		.cmd             (cmd),
		.sts             (sts),
		.res_valid       (result.valid),
		.res_ready       (result.ready),
		.sample_index    (result.sample_index),
		.draw_number     (result.draw_number),
		.last_in_run     (result.last_in_run)
	);

	assign draw.ready = cmd.ready;

	a_busy_not_ready: assert property (@(posedge clk) disable iff (!arst_n)
		draw.ready |-> !(cmd.sweep || cmd.mul || cmd.rd || cmd.wr1 || cmd.wr2))
		else $error("draw channel open while a draw is in progress");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.load_boot || cmd.load_jack) |-> sts.out_free)
		else $error("result loaded over a pending result");

	a_valid_from_load: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result.valid) |-> $past(cmd.load_boot || cmd.load_jack))
		else $error("result valid without a load");

	a_swap_order: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr2 |-> $past(cmd.wr1))
		else $error("second swap write without the first");

endmodule

@@ rtl/rig_ctrl.sv @@
// Sequencer of the resample index generator: steps each draw through a restart
// sweep when due, multiply and, in jackknife mode, table read and table writes. Depends on rig_pkg.
module rig_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              new_run,
	input  rig_pkg::rig_sts_t sts,
	output rig_pkg::rig_cmd_t cmd
);
	import rig_pkg::*;

	localparam logic [2:0] S_INIT  = 3'd0;
	localparam logic [2:0] S_IDLE  = 3'd1;
	localparam logic [2:0] S_SWEEP = 3'd2;
	localparam logic [2:0] S_MUL   = 3'd3;
	localparam logic [2:0] S_RD    = 3'd4;
	localparam logic [2:0] S_WR1   = 3'd5;
	localparam logic [2:0] S_WR2   = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_d;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_INIT: begin
				cmd.sweep = 1'b1;
				if (sts.sweep_last) state_d = S_IDLE;
			end
			S_IDLE: begin
				cmd.ready = 1'b1;
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_d = (new_run && !sts.clean_zero) ? S_SWEEP : S_MUL;
				end
			end
			S_SWEEP: begin
				cmd.sweep = 1'b1;
				if (sts.sweep_last) state_d = S_MUL;
			end
			S_MUL: begin
				// finished run: drop the draw
				if (sts.run_over) begin
					state_d = S_IDLE;
				end else begin
					cmd.mul = 1'b1;
					state_d = S_RD;
				end
			end
			S_RD: begin
				if (sts.jack) begin
					cmd.rd  = 1'b1;
					state_d = S_WR1;
				end else if (sts.out_free) begin
					cmd.load_boot = 1'b1;
					state_d = S_IDLE;
				end
			end
			S_WR1: begin
				// hold the swap until the result register frees up
				if (sts.out_free) begin
					cmd.wr1       = 1'b1;
					cmd.load_jack = 1'b1;
					state_d = S_WR2;
				end
			end
			S_WR2: begin
				cmd.wr2 = 1'b1;
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

@@ rtl/rig_datapath.sv @@
// Datapath of the resample index generator: configuration registers,
// multipliers, draw counter, index table memory and result register. Depends on rig_pkg.
module rig_datapath #(
	parameter int MAX_SAMPLES = rig_pkg::RIG_MAX_SAMPLES_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                wr_en,
	input  logic [rig_pkg::RIG_CFG_IDX_W-1:0]   wr_index,
	input  logic [rig_pkg::RIG_CFG_DATA_W-1:0]  wr_data,
	input  logic [rig_pkg::RIG_FRAC_W-1:0]      random_fraction,
	input  logic                                new_run,
	input  rig_pkg::rig_cmd_t                   cmd,
	output rig_pkg::rig_sts_t                   sts,
	output logic                                res_valid,
	input  logic                                res_ready,
	output logic [rig_pkg::RIG_IDX_W-1:0]       sample_index,
	output logic [rig_pkg::RIG_IDX_W-1:0]       draw_number,
	output logic                                last_in_run
);
	import rig_pkg::*;

	localparam int AW     = $clog2(MAX_SAMPLES);
	localparam int CL_W   = $clog2(MAX_SAMPLES + 1);
	localparam int PROD_W = RIG_COUNT_W + RIG_FRAC_W;
	localparam int TOT_W  = RIG_COUNT_W + RIG_RATIO_W;
	localparam int EXT_W  = AW + RIG_IDX_W;

	// configuration
	logic                   mode_q;
	logic [RIG_COUNT_W-1:0] sample_count_q;
	logic [RIG_RATIO_W-1:0] keep_ratio_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q         <= RIG_MODE_BOOT;
			sample_count_q <= RIG_COUNT_RST;
			keep_ratio_q   <= RIG_RATIO_RST;
		end else if (wr_en) begin
			case (wr_index)
				RIG_REG_MODE:  mode_q         <= wr_data[0];
				RIG_REG_COUNT: sample_count_q <= wr_data[RIG_COUNT_W-1:0];
				RIG_REG_RATIO: keep_ratio_q   <= wr_data[RIG_RATIO_W-1:0];
				default: ;
			endcase
		end
	end

	// run total, taken at the draw transfer
	logic [RIG_COUNT_W-1:0] count_eff;
	logic [RIG_RATIO_W-1:0] ratio_sat;
	logic [TOT_W-1:0]       tot_prod;
	logic [RIG_COUNT_W-1:0] total_d;

	assign count_eff = (32'(sample_count_q) > 32'(MAX_SAMPLES)) ?
		RIG_COUNT_W'(MAX_SAMPLES) : sample_count_q;
	assign ratio_sat = (keep_ratio_q > RIG_RATIO_ONE) ? RIG_RATIO_ONE : keep_ratio_q;
	assign tot_prod  = TOT_W'(count_eff) * TOT_W'(ratio_sat);
	assign total_d   = (mode_q == RIG_MODE_JACK) ?
		tot_prod[RIG_RATIO_FRAC +: RIG_COUNT_W] : count_eff;

	logic [RIG_FRAC_W-1:0]  frac_q;
	logic [RIG_COUNT_W-1:0] count_q;
	logic [RIG_COUNT_W-1:0] total_q;
	logic [RIG_COUNT_W-1:0] d_q;

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			frac_q  <= random_fraction;
			count_q <= count_eff;
			total_q <= total_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			d_q <= '0;
		end else if (cmd.accept && new_run) begin
			d_q <= '0;
		end else if (cmd.load_boot || cmd.load_jack) begin
			d_q <= d_q + RIG_COUNT_W'(1);
		end
	end

	// draw product: count*u in bootstrap, (count-d)*u in jackknife
	logic [RIG_COUNT_W-1:0] mul_a;
	logic [PROD_W-1:0]      prod_s1;
	logic [RIG_COUNT_W-1:0] quot;

	assign mul_a = (mode_q == RIG_MODE_JACK) ? (count_q - d_q) : count_q;

	always_ff @(posedge clk) begin
		if (cmd.mul) prod_s1 <= PROD_W'(mul_a) * PROD_W'(frac_q);
	end

	assign quot = prod_s1[RIG_FRAC_W +: RIG_COUNT_W];

	// pick position, clamped below the count
	logic [RIG_COUNT_W:0]   pick_sum;
	logic [RIG_COUNT_W-1:0] pick_lim;
	logic [AW-1:0]          pick_addr;
	logic [AW-1:0]          d_addr;

	assign pick_sum  = {1'b0, d_q} + {1'b0, quot};
	assign pick_lim  = (pick_sum >= {1'b0, count_q}) ?
		(count_q - RIG_COUNT_W'(1)) : pick_sum[RIG_COUNT_W-1:0];
	assign pick_addr = AW'(pick_lim);
	assign d_addr    = AW'(d_q);

	// index table: entries below clean_lim_q may differ from identity
	logic [AW-1:0]   tbl_mem [MAX_SAMPLES];
	logic [AW-1:0]   pick_q;
	logic [AW-1:0]   d_addr_q;
	logic [AW-1:0]   rd_pick_q;
	logic [AW-1:0]   rd_d_q;
	logic [AW-1:0]   sweep_q;
	logic [CL_W-1:0] clean_lim_q;
	logic [CL_W-1:0] pick_next;
	logic            mem_we;
	logic [AW-1:0]   mem_wa;
	logic [AW-1:0]   mem_wd;

	always_comb begin
		mem_we = cmd.sweep || cmd.wr1 || cmd.wr2;
		mem_wa = sweep_q;
		mem_wd = sweep_q;
		if (cmd.wr1) begin
			mem_wa = pick_q;
			mem_wd = rd_d_q;
		end else if (cmd.wr2) begin
			mem_wa = d_addr_q;
			mem_wd = rd_pick_q;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) tbl_mem[mem_wa] <= mem_wd;
		if (cmd.rd) begin
			rd_pick_q <= tbl_mem[pick_addr];
			rd_d_q    <= tbl_mem[d_addr];
			pick_q    <= pick_addr;
			d_addr_q  <= d_addr;
		end
	end

	assign pick_next = CL_W'(pick_q) + CL_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_q     <= '0;
			clean_lim_q <= CL_W'(MAX_SAMPLES);
		end else if (cmd.sweep) begin
			if (sts.sweep_last) begin
				sweep_q     <= '0;
				clean_lim_q <= '0;
			end else begin
				sweep_q <= sweep_q + AW'(1);
			end
		end else if (cmd.wr1 && (pick_next > clean_lim_q)) begin
			// the draw-position write lies at or below pick
			clean_lim_q <= pick_next;
		end
	end

	// result register
	logic                 res_valid_q;
	logic [EXT_W-1:0]     entry_ext;
	logic                 last_d;

	assign entry_ext = EXT_W'(rd_pick_q);
	assign last_d    = (({1'b0, d_q} + (RIG_COUNT_W+1)'(1)) == {1'b0, total_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (cmd.load_boot || cmd.load_jack) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_boot || cmd.load_jack) begin
			sample_index <= cmd.load_jack ? entry_ext[RIG_IDX_W-1:0] : quot[RIG_IDX_W-1:0];
			draw_number  <= d_q[RIG_IDX_W-1:0];
			last_in_run  <= last_d;
		end
	end

	assign res_valid = res_valid_q;

	assign sts.run_over   = (d_q >= total_q);
	assign sts.sweep_last = ((CL_W'(sweep_q) + CL_W'(1)) == clean_lim_q);
	assign sts.clean_zero = (clean_lim_q == '0);
	assign sts.jack       = (mode_q == RIG_MODE_JACK);
	assign sts.out_free   = !res_valid_q || res_ready;

endmodule

@@ dv/resample_index_generator_core_tb.sv @@
// Self-checking testbench of resample_index_generator_core, bootstrap and jackknife modes.
// Depends on rig_pkg, rig_draw_if, rig_result_if and the core; a typed-in table leads,
// random runs follow, and every result is checked in order against given or predicted values.
module resample_index_generator_core_tb;
	import rig_pkg::*;

	localparam int TABLE_DEPTH    = RIG_MAX_SAMPLES_DEF;
	localparam int SETTLE_CYCLES  = TABLE_DEPTH + 80;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int RANDOM_TARGET  = 450;
	localparam logic [RIG_CFG_IDX_W-1:0] RIG_REG_UNUSED = 2'd3;

	typedef struct packed {
		logic [RIG_IDX_W-1:0] sample_index;
		logic [RIG_IDX_W-1:0] draw_number;
		logic                 last_in_run;
	} pick_t;

	typedef enum logic {ROW_CFG, ROW_DRAW} row_kind_e;
	typedef enum logic [1:0] {CHK_MODEL, CHK_GIVEN, CHK_NONE} check_e;

	typedef struct {
		row_kind_e                 kind;
		logic [RIG_CFG_IDX_W-1:0]  sel;
		logic [RIG_CFG_DATA_W-1:0] data;
		logic [RIG_FRAC_W-1:0]     frac;
		logic                      new_run;
		check_e                    check;
		pick_t                     given;
	} step_row_t;

	logic                      clk;
	logic                      arst_n;
	logic                      wr_en;
	logic [RIG_CFG_IDX_W-1:0]  wr_index;
	logic [RIG_CFG_DATA_W-1:0] wr_data;

	rig_draw_if   draw_bus ();
	rig_result_if result_bus ();

	resample_index_generator_core #(.MAX_SAMPLES(TABLE_DEPTH)) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.draw     (draw_bus),
		.result   (result_bus)
	);

	// predictor state
	logic [RIG_IDX_W-1:0]   perm_table [TABLE_DEPTH];
	int unsigned            drawn_count;
	logic                   cfg_mode;
	logic [RIG_COUNT_W-1:0] cfg_count;
	logic [RIG_RATIO_W-1:0] cfg_ratio;

	pick_t     pending_picks [$];
	step_row_t script [$];
	int        fault_count;
	int        picks_checked;
	int        draws_sent;
	int        writes_done;
	int        stall_left;
	int        quiet_cycles;
	bit        steady;

	initial clk = 1'b0;
	always #10 clk = ~clk;

	function automatic int unsigned samples_in_use();
		return (cfg_count > TABLE_DEPTH) ? TABLE_DEPTH : cfg_count;
	endfunction

	function automatic int unsigned draws_in_run();
		longint unsigned ratio;
		ratio = (cfg_ratio > RIG_RATIO_ONE) ? RIG_RATIO_ONE : cfg_ratio;
		if (cfg_mode == RIG_MODE_BOOT)
			return samples_in_use();
		return int'((longint'(samples_in_use()) * ratio) >> RIG_RATIO_FRAC);
	endfunction

	// Advance the predictor by one accepted draw; returns 1 if it yields an index.
	function automatic bit forecast_pick(input logic [RIG_FRAC_W-1:0] frac, input logic nr,
			output pick_t res);
		int unsigned     count;
		int unsigned     total;
		int unsigned     pick;
		logic [RIG_IDX_W-1:0] idx;
		longint unsigned u;
		res = '0;
		u = frac;
		if (nr) begin
			for (int k = 0; k < TABLE_DEPTH; k++)
				perm_table[k] = k[RIG_IDX_W-1:0];
			drawn_count = 0;
		end
		count = samples_in_use();
		total = draws_in_run();
		if (drawn_count >= total)
			return 1'b0;
		if (cfg_mode == RIG_MODE_BOOT) begin
			idx = RIG_IDX_W'((longint'(count) * u) >> 32);
		end else begin
			pick = drawn_count + int'((longint'(count - drawn_count) * u) >> 32);
			if (pick >= count)
				pick = count - 1;
			idx = perm_table[pick];
			perm_table[pick] = perm_table[drawn_count];
			perm_table[drawn_count] = idx;
		end
		res.sample_index = idx;
		res.draw_number  = drawn_count[RIG_IDX_W-1:0];
		res.last_in_run  = (drawn_count + 1 == total);
		drawn_count++;
		return 1'b1;
	endfunction

	function automatic int idle_span();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(4, 30);
	endfunction

	function automatic step_row_t cfg_row(input logic [RIG_CFG_IDX_W-1:0] sel,
			input logic [RIG_CFG_DATA_W-1:0] data);
		step_row_t row;
		row = '{ROW_CFG, sel, data, '0, 1'b0, CHK_NONE, '0};
		return row;
	endfunction

	function automatic step_row_t draw_row(input logic [RIG_FRAC_W-1:0] frac, input logic nr,
			input check_e chk, input pick_t given);
		step_row_t row;
		row = '{ROW_DRAW, RIG_REG_MODE, '0, frac, nr, chk, given};
		return row;
	endfunction

	// Leaves wr_en high; the caller drops it after the last write of a batch.
	task automatic write_reg(input logic [RIG_CFG_IDX_W-1:0] sel,
			input logic [RIG_CFG_DATA_W-1:0] data);
		wr_en    <= 1'b1;
		wr_index <= sel;
		wr_data  <= data;
		@(posedge clk);
		writes_done++;
		case (sel)
			RIG_REG_MODE:  cfg_mode  = data[0];
			RIG_REG_COUNT: cfg_count = data[RIG_COUNT_W-1:0];
			RIG_REG_RATIO: cfg_ratio = data[RIG_RATIO_W-1:0];
			default: ;
		endcase
	endtask

	// Leaves valid high so back-to-back transfers need no second assignment.
	task automatic push_draw(input logic [RIG_FRAC_W-1:0] frac, input logic nr,
			input check_e chk, input pick_t given, output bit hit);
		pick_t got;
		draw_bus.valid           <= 1'b1;
		draw_bus.random_fraction <= frac;
		draw_bus.new_run         <= nr;
		do @(posedge clk); while (!draw_bus.ready);
		draws_sent++;
		hit = forecast_pick(frac, nr, got);
		if (chk == CHK_GIVEN) begin
			got = given;
			hit = 1'b1;
		end else if (chk == CHK_NONE) begin
			hit = 1'b0;
		end
		if (hit)
			pending_picks.push_back(got);
	endtask

	task automatic sender_gap();
		int n;
		n = steady ? 0 : idle_span();
		if (n != 0) begin
			draw_bus.valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	// Hold the sender until every outstanding index has arrived.
	task automatic drain();
		draw_bus.valid <= 1'b0;
		do @(posedge clk); while (pending_picks.size() != 0);
	endtask

	// Let a trailing restart sweep or resultless draw finish before touching registers.
	task automatic settle();
		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// result side: random backpressure and in-order compare
	always @(posedge clk) begin
		pick_t want;
		if (arst_n) begin
			if (result_bus.valid && result_bus.ready) begin
				if (pending_picks.size() == 0) begin
					$error("unexpected result: sample_index %0d draw_number %0d last_in_run %0b",
						result_bus.sample_index, result_bus.draw_number,
						result_bus.last_in_run);
					fault_count++;
				end else begin
					want = pending_picks.pop_front();
					picks_checked++;
					if (result_bus.sample_index !== want.sample_index) begin
						$error("sample_index: expected %0d, actual %0d",
							want.sample_index, result_bus.sample_index);
						fault_count++;
					end
					if (result_bus.draw_number !== want.draw_number) begin
						$error("draw_number: expected %0d, actual %0d",
							want.draw_number, result_bus.draw_number);
						fault_count++;
					end
					if (result_bus.last_in_run !== want.last_in_run) begin
						$error("last_in_run: expected %0b, actual %0b",
							want.last_in_run, result_bus.last_in_run);
						fault_count++;
					end
				end
			end
			if (stall_left != 0) begin
				result_bus.ready <= 1'b0;
				stall_left--;
			end else begin
				result_bus.ready <= 1'b1;
				if (!steady && $urandom_range(0, 3) == 0)
					stall_left = idle_span();
			end
		end
	end

	always @(posedge clk) begin
		if ((draw_bus.valid && draw_bus.ready) || (result_bus.valid && result_bus.ready) || wr_en)
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	initial begin
		bit          hit;
		bit          fresh;
		bit          writing;
		int          random_hits;
		int unsigned total;
		int unsigned remaining;
		int          n;
		int          r;
		logic        nr;
		logic        mode_pick;
		logic [RIG_COUNT_W-1:0] count_pick;
		logic [RIG_RATIO_W-1:0] ratio_pick;
		logic [RIG_FRAC_W-1:0]  frac;

		arst_n                   = 1'b0;
		wr_en                    = 1'b0;
		wr_index                 = RIG_REG_MODE;
		wr_data                  = '0;
		draw_bus.valid           = 1'b0;
		draw_bus.random_fraction = '0;
		draw_bus.new_run         = 1'b0;
		result_bus.ready         = 1'b0;
		fault_count   = 0;
		picks_checked = 0;
		draws_sent    = 0;
		writes_done   = 0;
		stall_left    = 0;
		quiet_cycles  = 0;
		steady        = 1'b0;
		random_hits   = 0;
		writing       = 1'b0;
		for (int k = 0; k < TABLE_DEPTH; k++)
			perm_table[k] = k[RIG_IDX_W-1:0];
		drawn_count = 0;
		cfg_mode    = RIG_MODE_BOOT;
		cfg_count   = RIG_COUNT_RST;
		cfg_ratio   = RIG_RATIO_RST;

		// reset values: bootstrap over 1024 samples
		script.push_back(draw_row(32'h0000_0000, 1'b1, CHK_GIVEN, '{10'd0, 10'd0, 1'b0}));
		script.push_back(draw_row(32'hFFFF_FFFF, 1'b0, CHK_GIVEN, '{10'd1023, 10'd1, 1'b0}));
		script.push_back(draw_row(32'h8000_0000, 1'b0, CHK_GIVEN, '{10'd512, 10'd2, 1'b0}));
		// single-sample run, then a draw past its end
		script.push_back(cfg_row(RIG_REG_COUNT, 17'd1));
		script.push_back(draw_row(32'hFFFF_FFFF, 1'b1, CHK_GIVEN, '{10'd0, 10'd0, 1'b1}));
		script.push_back(draw_row(32'h1234_5678, 1'b0, CHK_NONE, '0));
		// full jackknife over four samples: swap at draw 1 shows up at draw 3
		script.push_back(cfg_row(RIG_REG_MODE, 17'h00001));
		script.push_back(cfg_row(RIG_REG_COUNT, 17'd4));
		script.push_back(cfg_row(RIG_REG_RATIO, 17'h10000));
		script.push_back(draw_row(32'h0000_0000, 1'b1, CHK_GIVEN, '{10'd0, 10'd0, 1'b0}));
		script.push_back(draw_row(32'hFFFF_FFFF, 1'b0, CHK_GIVEN, '{10'd3, 10'd1, 1'b0}));
		script.push_back(draw_row(32'h0000_0000, 1'b0, CHK_GIVEN, '{10'd2, 10'd2, 1'b0}));
		script.push_back(draw_row(32'h8000_0000, 1'b0, CHK_GIVEN, '{10'd1, 10'd3, 1'b1}));
		script.push_back(draw_row(32'hFFFF_FFFF, 1'b0, CHK_NONE, '0));
		// zero ratio gives an empty run
		script.push_back(cfg_row(RIG_REG_RATIO, 17'd0));
		script.push_back(draw_row(32'h5555_5555, 1'b1, CHK_NONE, '0));
		// oversized count and ratio clip to the table size and to one
		script.push_back(cfg_row(RIG_REG_COUNT, 17'h1F7FF));
		script.push_back(cfg_row(RIG_REG_RATIO, 17'h1FFFF));
		script.push_back(draw_row(32'hFFFF_FFFF, 1'b1, CHK_GIVEN, '{10'd1023, 10'd0, 1'b0}));
		script.push_back(draw_row(32'hAAAA_AAAA, 1'b0, CHK_MODEL, '0));
		// zero count never yields
		script.push_back(cfg_row(RIG_REG_COUNT, 17'd0));
		script.push_back(draw_row(32'h0000_0000, 1'b1, CHK_NONE, '0));
		script.push_back(draw_row(32'hFFFF_FFFF, 1'b0, CHK_NONE, '0));
		// quarter ratio of eight samples: two draws
		script.push_back(cfg_row(RIG_REG_COUNT, 17'd8));
		script.push_back(cfg_row(RIG_REG_RATIO, 17'd16384));
		script.push_back(draw_row(32'h7FFF_FFFF, 1'b1, CHK_MODEL, '0));
		script.push_back(draw_row(32'h8000_0001, 1'b0, CHK_MODEL, '0));
		script.push_back(draw_row(32'h0000_0001, 1'b0, CHK_MODEL, '0));
		// switch to bootstrap mid-run; junk upper bits and an unused index are ignored
		script.push_back(cfg_row(RIG_REG_MODE, 17'h1FFFE));
		script.push_back(cfg_row(RIG_REG_COUNT, 17'd3));
		script.push_back(cfg_row(RIG_REG_UNUSED, 17'h1FFFF));
		script.push_back(draw_row(32'hFFFF_FFFF, 1'b0, CHK_MODEL, '0));
		script.push_back(draw_row(32'hFFFF_FFFF, 1'b1, CHK_GIVEN, '{10'd2, 10'd0, 1'b0}));

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		foreach (script[i]) begin
			if (script[i].kind == ROW_CFG) begin
				if (!writing)
					settle();
				write_reg(script[i].sel, script[i].data);
				writing = 1'b1;
			end else begin
				if (writing)
					wr_en <= 1'b0;
				else
					sender_gap();
				writing = 1'b0;
				push_draw(script[i].frac, script[i].new_run, script[i].check,
					script[i].given, hit);
			end
		end

		// random runs, one register setting per phase
		while (random_hits < RANDOM_TARGET) begin
			settle();
			steady = ($urandom_range(0, 4) == 0);
			mode_pick = 1'($urandom_range(0, 1));
			r = $urandom_range(0, 99);
			if (r < 70)
				count_pick = RIG_COUNT_W'($urandom_range(1, 12));
			else if (r < 90)
				count_pick = RIG_COUNT_W'($urandom_range(13, 64));
			else if (r < 96)
				count_pick = RIG_COUNT_W'($urandom_range(1000, 2047));
			else
				count_pick = '0;
			r = $urandom_range(0, 99);
			if (r < 40)
				ratio_pick = RIG_RATIO_ONE;
			else if (r < 60)
				ratio_pick = RIG_RATIO_W'($urandom_range(32768, 65535));
			else if (r < 80)
				ratio_pick = RIG_RATIO_W'($urandom_range(0, 131071));
			else
				ratio_pick = RIG_RATIO_W'($urandom_range(0, 32767));
			if (writes_done < 12 || $urandom_range(0, 2) != 0)
				write_reg(RIG_REG_MODE, {16'($urandom), mode_pick});
			if ($urandom_range(0, 2) != 0)
				write_reg(RIG_REG_COUNT, {6'($urandom), count_pick});
			if ($urandom_range(0, 2) != 0)
				write_reg(RIG_REG_RATIO, ratio_pick);
			if ($urandom_range(0, 9) == 0)
				write_reg(RIG_REG_UNUSED, 17'($urandom));
			wr_en <= 1'b0;

			fresh = ($urandom_range(0, 6) != 0);
			total = draws_in_run();
			if (fresh)
				remaining = total;
			else
				remaining = (total > drawn_count) ? total - drawn_count : 0;
			n = (remaining > 40) ? 40 : remaining;
			if ($urandom_range(0, 4) == 0)
				n += $urandom_range(1, 2);
			if (n == 0)
				n = 1;

			for (int k = 0; k < n; k++) begin
				if (k != 0) begin
					sender_gap();
					if ($urandom_range(0, 39) == 0)
						drain();
				end
				nr = (k == 0 && fresh) || ($urandom_range(0, 29) == 0);
				r = $urandom_range(0, 99);
				if (r < 4)
					frac = '0;
				else if (r < 8)
					frac = '1;
				else if (r < 10)
					frac = 32'h8000_0000;
				else
					frac = $urandom;
				push_draw(frac, nr, CHK_MODEL, '0, hit);
				if (hit)
					random_hits++;
			end
		end

		steady = 1'b0;
		settle();

		$display("Run covered %0d draws, %0d indices checked, %0d register writes,",
			draws_sent, picks_checked, writes_done);
		$display("both modes, clipped and empty runs, restarts and draws past the run end.");
		if (fault_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
